FILE: rtl/core/dtpl_pkg.sv
`timescale 1ns / 1ps

package dtpl_pkg;

    typedef logic [3:0] cfg_index_t;

    localparam cfg_index_t REG_LIGHT_X   = 4'd0;
    localparam cfg_index_t REG_LIGHT_Y   = 4'd1;
    localparam cfg_index_t REG_LIGHT_Z   = 4'd2;
    localparam cfg_index_t REG_LIGHT_PWR = 4'd3;
    localparam cfg_index_t REG_AMB_PWR   = 4'd4;
    localparam cfg_index_t REG_REFLECT_R = 4'd5;
    localparam cfg_index_t REG_REFLECT_G = 4'd6;
    localparam cfg_index_t REG_REFLECT_B = 4'd7;

    localparam logic [15:0] RST_LIGHT_X   = 16'h0000;
    localparam logic [15:0] RST_LIGHT_Y   = 16'hF800;
    localparam logic [15:0] RST_LIGHT_Z   = 16'hF4CD;
    localparam logic [15:0] RST_LIGHT_PWR = 16'd3584;
    localparam logic [15:0] RST_AMB_PWR   = 16'd128;

    // 1/(4*pi) in Q0.16
    localparam logic [18:0] INV_FOUR_PI_Q16 = 19'd5215;
    localparam logic [18:0] SCALE_255       = 19'd255;
    localparam logic [24:0] LIGHT_SAT       = 25'h1000000;

endpackage

FILE: rtl/core/dtpl_ram.sv
`timescale 1ns / 1ps

module dtpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/depth_tested_point_light_shader.sv
`timescale 1ns / 1ps
// Depth-tested fragment shader with one diffuse point light.
// Input channel (in_valid/in_ready): req_type 0 shades a fragment, 1 clears
// the depth buffer. Config channel (cfg_valid/cfg_ready) is always ready;
// write it only while the block is idle.
// A shade word inside the buffer reads the stored depth; if its inv_depth is
// strictly greater, the depth is replaced and one colour word comes out on
// out_valid/out_ready. Otherwise no word is produced and the block returns to
// idle through its read and test states; a word outside the buffer is dropped
// at once and the next one can be taken on the following cycle.
// A drawn fragment holds in_ready low until its colour word is loaded into the
// output register; on the way the shared 50x19 multiplier runs fifteen
// products, the square root takes 17 steps and the falloff divide 25 steps,
// one quotient bit per cycle. When the direct term is zero or saturated the
// divide is skipped.
// A clear keeps in_ready low while it zeroes every buffer entry, one
// entry per cycle. After reset the same clearing pass runs first and
// in_ready stays low until it ends.
// The finished colour sits in an output register; a stalled receiver does
// not stop the next fragment, which waits at its end only if the output
// register is still full.
module depth_tested_point_light_shader
    import dtpl_pkg::*;
#(
    parameter int BUF_WIDTH  = 512,
    parameter int BUF_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [11:0] frag_x,
    input  logic signed [11:0] frag_y,
    input  logic [23:0]        inv_depth,
    input  logic signed [15:0] world_x,
    input  logic signed [15:0] world_y,
    input  logic signed [15:0] world_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [8:0]         out_x,
    output logic [8:0]         out_y,
    output logic [7:0]         colour_r,
    output logic [7:0]         colour_g,
    output logic [7:0]         colour_b,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  cfg_index_t         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int DEPTH = BUF_WIDTH * BUF_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_TEST   = 4'd3;
    localparam logic [3:0] S_DOT    = 4'd4;
    localparam logic [3:0] S_R2     = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_R3     = 4'd7;
    localparam logic [3:0] S_NUM1   = 4'd8;
    localparam logic [3:0] S_NUM2   = 4'd9;
    localparam logic [3:0] S_DIVSET = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_TOTAL  = 4'd12;
    localparam logic [3:0] S_CHAN   = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    // configuration
    logic signed [15:0] light_x_reg, light_y_reg, light_z_reg;
    logic [15:0] light_pwr_reg, amb_pwr_reg;
    logic [12:0] refl_r_reg, refl_g_reg, refl_b_reg;

    // control
    logic [3:0]    state_reg, state_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    logic [AW-1:0]      idx_reg, idx_next;
    logic [8:0]         x_reg, x_next, y_reg, y_next;
    logic [23:0]        zinv_reg, zinv_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic signed [15:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic signed [68:0] prod_reg, prod_next;
    logic signed [35:0] dot_reg, dot_next;
    logic [34:0]        r2_reg, r2_next;
    logic [34:0]        sq_v_reg, sq_v_next, sq_res_reg, sq_res_next;
    logic [34:0]        sq_bit_reg, sq_bit_next;
    logic [50:0]        r3_reg, r3_next;
    logic [61:0]        rem_reg, rem_next;
    logic [80:0]        dv_reg, dv_next;
    logic [24:0]        q_reg, q_next;
    logic [24:0]        direct_reg, direct_next, total_reg, total_next;
    logic [7:0]         col_r_reg, col_r_next, col_g_reg, col_g_next;
    logic [7:0]         col_b_reg, col_b_next;
    logic [8:0]         ox_reg, ox_next, oy_reg, oy_next;
    logic [7:0]         or_reg, or_next, og_reg, og_next, ob_reg, ob_next;

    // shared multiplier operands
    logic signed [49:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [16:0] d_sel;
    logic signed [15:0] n_sel;
    logic [12:0]        refl_sel;

    // depth buffer port
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [23:0]   ram_wdata, ram_rdata;

    logic        accept;
    logic        in_range;
    logic [31:0] idx_wide;
    logic [34:0] sq_t;
    logic [56:0] den;
    logic [24:0] q_step;
    logic [25:0] sum_total;
    logic [7:0]  col_val;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign colour_r  = or_reg;
    assign colour_g  = og_reg;
    assign colour_b  = ob_reg;

    assign in_range = !frag_x[11] && !frag_y[11]
                   && (32'(frag_x[10:0]) < 32'(BUF_WIDTH))
                   && (32'(frag_y[10:0]) < 32'(BUF_HEIGHT));
    assign idx_wide = 32'(frag_y[10:0]) * 32'(BUF_WIDTH) + 32'(frag_x[10:0]);

    assign sq_t    = sq_res_reg + sq_bit_reg;
    assign den     = {r3_reg, 6'b0};
    assign col_val = (|prod_reg[44:28]) ? 8'hFF : prod_reg[27:20];

    dtpl_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_depth_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_addr  = (state_reg == S_CLEAR) ? clr_addr_reg : idx_reg;
        ram_we    = (state_reg == S_CLEAR)
                 || ((state_reg == S_TEST) && (zinv_reg > ram_rdata));
        ram_wdata = (state_reg == S_CLEAR) ? 24'd0 : zinv_reg;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin d_sel = dx_reg; n_sel = nx_reg; end
            2'd1:    begin d_sel = dy_reg; n_sel = ny_reg; end
            default: begin d_sel = dz_reg; n_sel = nz_reg; end
        endcase
        case (cnt_reg[2:1])
            2'd0:    refl_sel = refl_r_reg;
            2'd1:    refl_sel = refl_g_reg;
            default: refl_sel = refl_b_reg;
        endcase
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DOT:
            begin
                mul_a = {{33{d_sel[16]}}, d_sel};
                mul_b = {{3{n_sel[15]}}, n_sel};
            end
            S_R2:
            begin
                mul_a = {{33{d_sel[16]}}, d_sel};
                mul_b = {{2{d_sel[16]}}, d_sel};
            end
            S_R3:
            begin
                mul_a = {15'b0, r2_reg};
                mul_b = {2'b0, sq_res_reg[16:0]};
            end
            S_NUM1:
            begin
                mul_a = {{14{dot_reg[35]}}, dot_reg};
                mul_b = {3'b0, light_pwr_reg};
            end
            S_NUM2:
            begin
                mul_a = prod_reg[49:0];
                mul_b = INV_FOUR_PI_Q16;
            end
            S_CHAN:
            begin
                if (!cnt_reg[0])
                begin
                    mul_a = {25'b0, total_reg};
                    mul_b = {6'b0, refl_sel};
                end
                else
                begin
                    mul_a = prod_reg[49:0];
                    mul_b = SCALE_255;
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        zinv_next      = zinv_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nz_next        = nz_reg;
        dot_next       = dot_reg;
        r2_next        = r2_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        r3_next        = r3_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        direct_next    = direct_reg;
        total_next     = total_reg;
        col_r_next     = col_r_reg;
        col_g_next     = col_g_reg;
        col_b_next     = col_b_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        or_next        = or_reg;
        og_next        = og_reg;
        ob_next        = ob_reg;
        q_step         = '0;
        sum_total      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next    = frag_x[8:0];
                    y_next    = frag_y[8:0];
                    idx_next  = idx_wide[AW-1:0];
                    zinv_next = inv_depth;
                    dx_next   = 17'(light_x_reg) - 17'(world_x);
                    dy_next   = 17'(light_y_reg) - 17'(world_y);
                    dz_next   = 17'(light_z_reg) - 17'(world_z);
                    nx_next   = normal_x;
                    ny_next   = normal_y;
                    nz_next   = normal_z;
                    if (req_type)
                    begin
                        clr_addr_next = '0;
                        state_next    = S_CLEAR;
                    end
                    else if (in_range)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // drop the fragment unless it is strictly nearer
                if (zinv_reg > ram_rdata)
                begin
                    dot_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DOT:
            begin
                if (cnt_reg != 5'd0)
                begin
                    dot_next = dot_reg + prod_reg[35:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd3)
                begin
                    r2_next    = '0;
                    cnt_next   = '0;
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                if (cnt_reg != 5'd0)
                begin
                    r2_next = r2_reg + prod_reg[34:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd3)
                begin
                    sq_v_next   = r2_next;
                    sq_res_next = '0;
                    sq_bit_next = 35'h1_0000_0000;
                    cnt_next    = '0;
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_v_reg >= sq_t)
                begin
                    sq_v_next   = sq_v_reg - sq_t;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 5'd16)
                begin
                    state_next = S_R3;
                end
            end
            S_R3:
            begin
                state_next = S_NUM1;
            end
            S_NUM1:
            begin
                r3_next    = prod_reg[50:0];
                state_next = S_NUM2;
            end
            S_NUM2:
            begin
                state_next = S_DIVSET;
            end
            S_DIVSET:
            begin
                // light on the surface or facing away: no direct term
                if (dot_reg[35] || (dot_reg == 36'sd0) || (r3_reg == '0))
                begin
                    direct_next = '0;
                    state_next  = S_TOTAL;
                end
                else if ({20'b0, prod_reg[61:0]} >= {den, 25'b0})
                begin
                    direct_next = LIGHT_SAT;
                    state_next  = S_TOTAL;
                end
                else
                begin
                    rem_next   = prod_reg[61:0];
                    dv_next    = {den, 24'b0};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if ({19'b0, rem_reg} >= dv_reg)
                begin
                    rem_next = rem_reg - dv_reg[61:0];
                    q_step   = {q_reg[23:0], 1'b1};
                end
                else
                begin
                    q_step = {q_reg[23:0], 1'b0};
                end
                q_next   = q_step;
                dv_next  = dv_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd24)
                begin
                    direct_next = (q_step > LIGHT_SAT) ? LIGHT_SAT : q_step;
                    state_next  = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                sum_total  = {1'b0, direct_reg} + 26'(amb_pwr_reg);
                total_next = (sum_total > 26'(LIGHT_SAT)) ? LIGHT_SAT
                                                          : sum_total[24:0];
                cnt_next   = '0;
                state_next = S_CHAN;
            end
            S_CHAN:
            begin
                // even steps start a channel, odd steps scale by 255
                case (cnt_reg)
                    5'd2:    col_r_next = col_val;
                    5'd4:    col_g_next = col_val;
                    5'd6:    col_b_next = col_val;
                    default: ;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd6)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ox_next        = x_reg;
                    oy_next        = y_reg;
                    or_next        = col_r_reg;
                    og_next        = col_g_reg;
                    ob_next        = col_b_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            light_x_reg   <= RST_LIGHT_X;
            light_y_reg   <= RST_LIGHT_Y;
            light_z_reg   <= RST_LIGHT_Z;
            light_pwr_reg <= RST_LIGHT_PWR;
            amb_pwr_reg   <= RST_AMB_PWR;
            refl_r_reg    <= '0;
            refl_g_reg    <= '0;
            refl_b_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LIGHT_X:   light_x_reg   <= cfg_data;
                    REG_LIGHT_Y:   light_y_reg   <= cfg_data;
                    REG_LIGHT_Z:   light_z_reg   <= cfg_data;
                    REG_LIGHT_PWR: light_pwr_reg <= cfg_data;
                    REG_AMB_PWR:   amb_pwr_reg   <= cfg_data;
                    REG_REFLECT_R: refl_r_reg    <= cfg_data[12:0];
                    REG_REFLECT_G: refl_g_reg    <= cfg_data[12:0];
                    REG_REFLECT_B: refl_b_reg    <= cfg_data[12:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        zinv_reg   <= zinv_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        nz_reg     <= nz_next;
        prod_reg   <= prod_next;
        dot_reg    <= dot_next;
        r2_reg     <= r2_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        r3_reg     <= r3_next;
        rem_reg    <= rem_next;
        dv_reg     <= dv_next;
        q_reg      <= q_next;
        direct_reg <= direct_next;
        total_reg  <= total_next;
        col_r_reg  <= col_r_next;
        col_g_reg  <= col_g_next;
        col_b_reg  <= col_b_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        or_reg     <= or_next;
        og_reg     <= og_next;
        ob_reg     <= ob_next;
    end

endmodule

FILE: test/depth_tested_point_light_shader_tb.sv
`timescale 1ns / 1ps

module depth_tested_point_light_shader_tb
    import dtpl_pkg::*;
();

    localparam int XRES = 512;
    localparam int YRES = 512;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_WORDS = 1400;
    localparam int PHASES = 7;

    typedef enum logic {REQ_SHADE = 1'b0, REQ_CLEAR = 1'b1} req_kind_t;

    typedef struct {
        req_kind_t          kind;
        logic signed [11:0] fx;
        logic signed [11:0] fy;
        logic [23:0]        zinv;
        logic signed [15:0] wx, wy, wz;
        logic signed [15:0] nx, ny, nz;
    } frag_t;

    typedef struct {
        logic [8:0] px;
        logic [8:0] py;
        logic [7:0] r, g, b;
    } pixel_t;

    class shade_scoreboard;
        logic signed [15:0] lx, ly, lz;
        logic [15:0]        lpwr, amb;
        logic [12:0]        refl_r, refl_g, refl_b;
        logic [23:0]        zbuf [XRES*YRES];
        pixel_t             pixels_due [$];
        int                 errors;

        function void reset_state();
            lx = RST_LIGHT_X;
            ly = RST_LIGHT_Y;
            lz = RST_LIGHT_Z;
            lpwr = RST_LIGHT_PWR;
            amb = RST_AMB_PWR;
            refl_r = '0;
            refl_g = '0;
            refl_b = '0;
            foreach (zbuf[i]) zbuf[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                REG_LIGHT_X:   lx = val;
                REG_LIGHT_Y:   ly = val;
                REG_LIGHT_Z:   lz = val;
                REG_LIGHT_PWR: lpwr = val;
                REG_AMB_PWR:   amb = val;
                REG_REFLECT_R: refl_r = val[12:0];
                REG_REFLECT_G: refl_g = val[12:0];
                REG_REFLECT_B: refl_b = val[12:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function logic [7:0] channel(longint unsigned total, logic [12:0] refl);
            longint unsigned c;
            c = (total * refl * 255) >> 20;
            return (c > 255) ? 8'd255 : c[7:0];
        endfunction

        function void note_input(frag_t f);
            longint dx, dy, dz, dotp;
            longint unsigned r2, r, r3, direct, total;
            int idx;
            pixel_t p;
            if (f.kind == REQ_CLEAR) begin
                foreach (zbuf[i]) zbuf[i] = '0;
                return;
            end
            if (f.fx < 0 || f.fy < 0 || f.fx >= XRES || f.fy >= YRES) return;
            idx = int'(f.fy) * XRES + int'(f.fx);
            if (f.zinv <= zbuf[idx]) return;
            zbuf[idx] = f.zinv;
            dx = longint'(lx) - longint'(f.wx);
            dy = longint'(ly) - longint'(f.wy);
            dz = longint'(lz) - longint'(f.wz);
            dotp = dx * longint'(f.nx) + dy * longint'(f.ny) + dz * longint'(f.nz);
            r2 = dx * dx + dy * dy + dz * dz;
            r = root(r2);
            r3 = r2 * r;
            direct = 0;
            if (dotp > 0 && r3 != 0) begin
                direct = (longint'(lpwr) * dotp * 5215) / (r3 << 6);
                if (direct > (64'd1 << 24)) direct = 64'd1 << 24;
            end
            total = direct + amb;
            if (total > (64'd1 << 24)) total = 64'd1 << 24;
            p.px = f.fx[8:0];
            p.py = f.fy[8:0];
            p.r = channel(total, refl_r);
            p.g = channel(total, refl_g);
            p.b = channel(total, refl_b);
            pixels_due.push_back(p);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check(pixel_t got);
            pixel_t want;
            if (pixels_due.size() == 0) begin
                report($sformatf("unexpected pixel (%0d,%0d)", got.px, got.py));
                return;
            end
            want = pixels_due.pop_front();
            if (got.px != want.px) report($sformatf("out_x %0d, want %0d", got.px, want.px));
            if (got.py != want.py) report($sformatf("out_y %0d, want %0d", got.py, want.py));
            if (got.r != want.r) report($sformatf("colour_r %0d, want %0d", got.r, want.r));
            if (got.g != want.g) report($sformatf("colour_g %0d, want %0d", got.g, want.g));
            if (got.b != want.b) report($sformatf("colour_b %0d, want %0d", got.b, want.b));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = 1'b0;
    logic signed [11:0] frag_x = '0;
    logic signed [11:0] frag_y = '0;
    logic [23:0]        inv_depth = '0;
    logic signed [15:0] world_x = '0, world_y = '0, world_z = '0;
    logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [8:0]         out_x, out_y;
    logic [7:0]         colour_r, colour_g, colour_b;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    shade_scoreboard sb;
    bit  calm = 1'b0;
    int  cycles = 0;

    depth_tested_point_light_shader dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("depth_tested_point_light_shader test failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && out_valid && out_ready) begin
            got.px = out_x;
            got.py = out_y;
            got.r = colour_r;
            got.g = colour_g;
            got.b = colour_b;
            sb.check(got);
        end
    end

    // caller is at a clock edge; returns at the edge the word is taken, or after a random idle pause that follows it
    task send_word(frag_t f);
        in_valid <= 1'b1;
        req_type <= f.kind;
        frag_x <= f.fx;
        frag_y <= f.fy;
        inv_depth <= f.zinv;
        world_x <= f.wx;
        world_y <= f.wy;
        world_z <= f.wz;
        normal_x <= f.nx;
        normal_y <= f.ny;
        normal_z <= f.nz;
        do @(posedge clk); while (!in_ready);
        sb.note_input(f);
        if (!calm && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // hold until every pixel is out and the block has gone quiet
    task settle();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task program_light(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                       logic [15:0] pw, logic [15:0] am,
                       logic [15:0] rr, logic [15:0] rg, logic [15:0] rb);
        settle();
        write_reg(REG_LIGHT_X, px);
        write_reg(REG_LIGHT_Y, py);
        write_reg(REG_LIGHT_Z, pz);
        write_reg(REG_LIGHT_PWR, pw);
        write_reg(REG_AMB_PWR, am);
        write_reg(REG_REFLECT_R, rr);
        write_reg(REG_REFLECT_G, rg);
        write_reg(REG_REFLECT_B, rb);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function frag_t shade(int x, int y, int z, int wx, int wy, int wz,
                          int nx, int ny, int nz);
        frag_t f;
        f.kind = REQ_SHADE;
        f.fx = 12'(x);
        f.fy = 12'(y);
        f.zinv = 24'(z);
        f.wx = 16'(wx);
        f.wy = 16'(wy);
        f.wz = 16'(wz);
        f.nx = 16'(nx);
        f.ny = 16'(ny);
        f.nz = 16'(nz);
        return f;
    endfunction

    function frag_t random_frag();
        frag_t f;
        f = shade(0, 0, $urandom, 0, 0, 0, 0, 0, 0);
        if ($urandom_range(99) < 80) begin
            f.fx = 12'($urandom_range(31) + ($urandom_range(1) ? 480 : 0));
            f.fy = 12'($urandom_range(31) + ($urandom_range(1) ? 480 : 0));
        end
        else begin
            f.fx = 12'($urandom);
            f.fy = 12'($urandom);
        end
        if ($urandom_range(3) == 0) f.zinv = 24'($urandom_range(255));
        if ($urandom_range(1)) begin
            f.wx = 16'($urandom_range(8192) - 4096);
            f.wy = 16'($urandom_range(8192) - 4096);
            f.wz = 16'($urandom_range(8192) - 4096);
            f.nx = 16'($urandom_range(32768) - 16384);
            f.ny = 16'($urandom_range(32768) - 16384);
            f.nz = 16'($urandom_range(32768) - 16384);
        end
        else begin
            f.wx = 16'($urandom);
            f.wy = 16'($urandom);
            f.wz = 16'($urandom);
            f.nx = 16'($urandom);
            f.ny = 16'($urandom);
            f.nz = 16'($urandom);
        end
        return f;
    endfunction

    initial
    begin
        frag_t f;
        int per_phase;
        sb = new();
        sb.reset_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults give black pixels
        while (!in_ready) @(posedge clk);
        send_word(shade(5, 5, 100, 0, 0, 4096, 0, 0, -16384));

        program_light(16'd0, 16'hF800, 16'hF4CD, 16'd3584, 16'd128,
                      16'd4096, 16'd2048, 16'd1000);
        // out-of-range index must be ignored
        write_reg(cfg_index_t'(8), 16'hFFFF);
        write_reg(cfg_index_t'(15), 16'h1234);
        cfg_valid <= 1'b0;
        @(posedge clk);

        send_word(shade(0, 0, 1, 0, 0, 4096, 0, 0, -16384));
        send_word(shade(511, 511, 24'hFFFFFF, 32767, 32767, 32767, 16384, 16384, 16384));
        send_word(shade(511, 0, 24'h800000, -32768, -32768, -32768, -16384, 16384, -16384));
        send_word(shade(0, 511, 500, 4096, -4096, 0, 16384, 0, 0));
        // equal, lower and then higher depth at stored spots
        send_word(shade(0, 0, 1, 0, 0, 0, 0, 0, -16384));
        send_word(shade(511, 511, 24'hFFFFFE, 0, 0, 0, 0, 0, -16384));
        send_word(shade(0, 0, 2, 0, 0, 0, 0, 0, -16384));
        // outside the buffer
        send_word(shade(-1, 3, 9, 0, 0, 0, 0, 0, 0));
        send_word(shade(3, -1, 9, 0, 0, 0, 0, 0, 0));
        send_word(shade(512, 3, 9, 0, 0, 0, 0, 0, 0));
        send_word(shade(3, 512, 9, 0, 0, 0, 0, 0, 0));
        send_word(shade(2047, -2048, 9, 0, 0, 0, 0, 0, 0));
        send_word(shade(-2048, 2047, 9, 0, 0, 0, 0, 0, 0));
        // light sitting on the fragment
        send_word(shade(10, 10, 9, 0, -2048, -2867, 0, 16384, 0));
        // normal facing away, then two unnormalised ones
        send_word(shade(11, 10, 9, 0, 0, 4096, 0, 0, 16384));
        send_word(shade(12, 10, 9, 0, 0, -1000, -32768, 32767, -32768));
        send_word(shade(13, 10, 9, 0, -2000, -2800, 0, 32767, 32767));
        f = shade(0, 0, 0, 0, 0, 0, 0, 0, 0);
        f.kind = REQ_CLEAR;
        send_word(f);
        send_word(shade(0, 0, 1, 0, 0, 4096, 0, 0, -16384));

        // reflectance above one saturates the colour
        program_light(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                      16'h1FFF, 16'h1FFF, 16'h1FFF);
        send_word(shade(20, 20, 9, 10, 10, 10, -16384, -16384, -16384));
        send_word(shade(21, 20, 9, 4096, 0, 0, -16384, 0, 0));

        per_phase = RANDOM_WORDS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_light(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0,
                                 16'd4096, 16'd4096, 16'd4096);
                1: program_light(16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF,
                                 16'd0, 16'd1, 16'h1FFF);
                default: program_light(16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom),
                                       16'($urandom_range(1) ? $urandom_range(512)
                                                             : $urandom),
                                       16'($urandom_range(8191)),
                                       16'($urandom_range(4096)),
                                       16'($urandom_range(4096)));
            endcase
            calm = (p == 2);
            if (p == 3) begin
                f = shade(0, 0, 0, 0, 0, 0, 0, 0, 0);
                f.kind = REQ_CLEAR;
                send_word(f);
            end
            for (int i = 0; i < per_phase; i++) begin
                // pause the sender until the pipe is empty
                if (p == 4 && i == per_phase / 2) begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (sb.pixels_due.size() != 0);
                end
                send_word(random_frag());
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pixels_due.size() == 0)
            $display("depth_tested_point_light_shader test passed");
        else
            $display("depth_tested_point_light_shader test failed");
        $finish;
    end

endmodule
